// File: rtl/core/bounded_set_table_unit_assert.svh
// Assertion macros shared by the set table RTL.
`ifndef BOUNDED_SET_TABLE_UNIT_ASSERT_SVH
`define BOUNDED_SET_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BST_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("set table assertion failed");
`define BST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("set table assertion failed");
`else
`define BST_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/bst_pkg.sv
// Package with types and constants of the set table.
`timescale 1ns / 1ps
package bst_pkg;

  localparam int DEF_CAPACITY = 128;
  localparam int MAX_CNT_W    = 13;
  localparam int MAX_IDX_W    = 12;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_ENC,
    S_UPD
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                 cmp_en;
    logic                 ins_en;
    logic                 rem_en;
    logic [MAX_CNT_W-1:0] count;
    logic [MAX_IDX_W-1:0] at;
  } cell_ctrl_t;

endpackage

// File: rtl/core/bst_if.sv
// Handshake interfaces for the request and result items.
`timescale 1ns / 1ps
interface bst_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] item_value;

  modport source (output valid, output cmd, output item_value, input ready);
  modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

interface bst_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] position;
  logic [7:0] entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  output ready);
endinterface

// File: rtl/core/bst_cell.sv
// One storage cell of the set table: holds a value, compares, shifts down.
`timescale 1ns / 1ps
module bst_cell
  import bst_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  cell_ctrl_t  ctrl,
  input  logic [31:0] key,
  input  logic [31:0] next_value,
  output logic [31:0] value,
  output logic        match
);

  localparam logic [MAX_CNT_W-1:0] MY_IDX  = MAX_CNT_W'(IDX);
  localparam logic [MAX_CNT_W-1:0] MY_NEXT = MAX_CNT_W'(IDX + 1);

  logic [31:0] value_r, value_nxt;
  logic        match_r, match_nxt;
  logic        occupied, load, shift;

  assign occupied = MY_IDX < ctrl.count;
  assign load     = ctrl.ins_en && (MY_IDX == ctrl.count);
  assign shift    = ctrl.rem_en && (MY_IDX >= MAX_CNT_W'(ctrl.at)) && (MY_NEXT < ctrl.count);

  always_comb begin
    value_nxt = value_r;
    if (load) begin
      value_nxt = key;
    end else if (shift) begin
      value_nxt = next_value;
    end
    match_nxt = ctrl.cmp_en ? (occupied && (value_r == key)) : match_r;
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    match_r <= match_nxt;
  end

  assign value = value_r;
  assign match = match_r;

endmodule

// File: rtl/core/bst_enc.sv
// Encoder that turns the cells' match flags into a hit flag and a position.
`timescale 1ns / 1ps
module bst_enc
  import bst_pkg::*;
#(
  parameter int N  = DEF_CAPACITY,
  parameter int IW = 7
) (
  input  logic          clk,
  input  logic          en,
  input  logic [N-1:0]  match,
  output logic          hit,
  output logic [IW-1:0] pos
);

  logic          hit_r;
  logic [IW-1:0] pos_r, pos_c;

  // Held values are distinct, so at most one flag is set: OR the indexes.
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < N; i++) begin
      pos_c = pos_c | (match[i] ? IW'(i) : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= |match;
      pos_r <= pos_c;
    end
  end

  assign hit = hit_r;
  assign pos = pos_r;

endmodule

// File: rtl/core/bounded_set_table_unit.sv
// Top level of the bounded set table: controller and the row of cells.
`timescale 1ns / 1ps
`include "bounded_set_table_unit_assert.svh"
// Bounded set table. Holds up to CAPACITY distinct 32-bit values in the
// order they were inserted, one value per cell in a row of cells. A request
// is a lookup, insert or remove of one value and yields exactly one result
// item: status (0 done/found, 1 duplicate/absent, 2 full), the position
// concerned (0 when status is nonzero) and the count after the request.
// An unused command code behaves as a lookup. A request accepted at a clock
// edge goes through the compare, encode and update states: every cell
// compares its value against the key and registers the outcome, the encoder
// turns the match flags into a position, and the cells are updated and the
// result register loaded. A removal shifts all later cells down one place
// in that single update step. The controller returns to idle after the
// update and takes the next request in the following cycle, even while the
// previous result still waits in the output register; a new request enters
// only once the last has finished its update. A stalled output holds the
// update until the result register frees up. No clearing pass is needed.
module bounded_set_table_unit
  import bst_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  bst_in_if.sink    in_ch,
  bst_out_if.source out_ch
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);

  state_t         state_r, state_nxt;
  logic [1:0]     cmd_r;
  logic [31:0]    key_r;
  logic [CW-1:0]  count_r, count_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [1:0]     status_r, status_nxt;
  logic [6:0]     position_r, position_nxt;
  logic [7:0]     entry_count_r, entry_count_nxt;

  logic           in_fire, out_free, upd_go;
  logic           hit;
  logic [IW-1:0]  hit_pos;
  logic           is_ins, is_rem, full, do_ins, do_rem;
  logic [IW-1:0]  res_pos;
  logic [31:0]    pos_ext, cnt_ext;

  logic [CAPACITY-1:0] match_vec;
  logic [31:0]         cell_val [CAPACITY+1];
  cell_ctrl_t          ctrl;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign upd_go   = (state_r == S_UPD) && out_free;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_ENC;
      S_ENC:  state_nxt = S_UPD;
      S_UPD:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the controller.
  always_comb begin
    in_ch.ready = (state_r == S_IDLE);
  end

  // Decide the request outcome from the encoded hit.
  assign is_ins = (cmd_r == CMD_INSERT);
  assign is_rem = (cmd_r == CMD_REMOVE);
  assign full   = (count_r == CNT_FULL);
  assign do_ins = upd_go && is_ins && !hit && !full;
  assign do_rem = upd_go && is_rem && hit;

  always_comb begin
    status_nxt = ST_OK;
    res_pos    = hit_pos;
    count_nxt  = count_r;
    priority if (is_ins) begin
      if (hit) begin
        status_nxt = ST_MISS;
      end else if (full) begin
        status_nxt = ST_FULL;
      end else begin
        res_pos = count_r[IW-1:0];
      end
    end else begin
      if (!hit) status_nxt = ST_MISS;
    end
    if (status_nxt != ST_OK) res_pos = '0;
    if (do_ins) count_nxt = count_r + CW'(1);
    if (do_rem) count_nxt = count_r - CW'(1);
  end

  // Mask position and count to the output widths.
  assign pos_ext = 32'(res_pos);
  assign cnt_ext = 32'(count_nxt);

  always_comb begin
    out_valid_nxt   = out_valid_r;
    position_nxt    = position_r;
    entry_count_nxt = entry_count_r;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (upd_go) begin
      out_valid_nxt   = 1'b1;
      position_nxt    = pos_ext[6:0];
      entry_count_nxt = cnt_ext[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the request and the result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_ch.cmd;
      key_r <= in_ch.item_value;
    end
    if (upd_go) status_r <= status_nxt;
    position_r    <= position_nxt;
    entry_count_r <= entry_count_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.position    = position_r;
  assign out_ch.entry_count = entry_count_r;

  // Broadcast control to the cells.
  always_comb begin
    ctrl        = '0;
    ctrl.cmp_en = (state_r == S_CMP);
    ctrl.ins_en = do_ins;
    ctrl.rem_en = do_rem;
    ctrl.count  = MAX_CNT_W'(count_r);
    ctrl.at     = MAX_IDX_W'(hit_pos);
  end

  // Row of cells; each takes its right neighbor's value on a removal.
  assign cell_val[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bst_cell #(
      .IDX(i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key       (key_r),
      .next_value(cell_val[i+1]),
      .value     (cell_val[i]),
      .match     (match_vec[i])
    );
  end

  bst_enc #(
    .N (CAPACITY),
    .IW(IW)
  ) u_enc (
    .clk  (clk),
    .en   (state_r == S_ENC),
    .match(match_vec),
    .hit  (hit),
    .pos  (hit_pos)
  );

  `BST_ASSERT_IMPLY(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_FULL)
  `BST_ASSERT_IMPLY(a_match_unique, clk, rst_n, state_r == S_ENC, $onehot0(match_vec))
  `BST_ASSERT_NEXT(a_upd_to_idle, clk, rst_n, upd_go, state_r == S_IDLE && out_valid_r)
  `BST_ASSERT_NEXT(a_count_step, clk, rst_n, !do_ins && !do_rem, $stable(count_r))

endmodule

// File: tb/sv/testbench.sv
// Testbench for the bounded set table: directed table plus random traffic against a predictor.
`timescale 1ns / 1ps
module testbench
  import bst_pkg::*;
();

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 12;
  localparam int TABLE_DEPTH  = DEF_CAPACITY;
  // Random traffic runs in episodes that alternately fill the table and drain it.
  localparam int RANDOM_ITEMS = 1740;
  localparam int EPISODE_LEN  = 290;
  localparam int IDLE_BLOCK   = 60;
  localparam int POOL_LIMIT   = 200;
  // Cycles to wait after the owed results are drained, before closing out.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int TIMEOUT_NS    = 2_000_000;

  // The package names three commands; the fourth code acts as a lookup.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] position;
    logic [7:0] entry_count;
  } set_result_t;

  // One request; typed rows carry a hand-written result that replaces the prediction.
  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] value;
    bit                 typed;
    set_result_t        result;
  } request_row_t;

  logic clk = 1'b0;
  logic rst_n;

  bst_in_if  in_ch ();
  bst_out_if out_ch ();

  bounded_set_table_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predictor state: the held values in insertion order.
  logic signed [31:0] set_contents[$];
  // Requests issued but not yet accepted, and results still owed by the block.
  request_row_t       pending_requests[$];
  set_result_t        expected_results[$];
  // Values likely held, used to steer random requests toward hits.
  logic signed [31:0] value_pool[$];
  // Shared by both sides: when clear, neither idles nor stalls.
  bit                 idle_on;
  int                 error_count;

  logic signed [31:0] boundary_values[4] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, -32'sd1};

  // Directed part: empty-table misses, extremes, duplicate, unused command,
  // removal at the middle, the head and the tail, and removal of an absent value.
  request_row_t directed_rows[20] = '{
    '{CMD_LOOKUP, 32'sd0,           1'b1, '{ST_MISS, 7'd0, 8'd0}},
    '{CMD_REMOVE, 32'sd0,           1'b1, '{ST_MISS, 7'd0, 8'd0}},
    '{CMD_INSERT, 32'sh8000_0000,   1'b1, '{ST_OK,   7'd0, 8'd1}},
    '{CMD_INSERT, 32'sh7FFF_FFFF,   1'b1, '{ST_OK,   7'd1, 8'd2}},
    '{CMD_INSERT, -32'sd1,          1'b1, '{ST_OK,   7'd2, 8'd3}},
    '{CMD_INSERT, 32'sd0,           1'b1, '{ST_OK,   7'd3, 8'd4}},
    '{CMD_INSERT, 32'sh7FFF_FFFF,   1'b1, '{ST_MISS, 7'd0, 8'd4}},
    '{CMD_LOOKUP, -32'sd1,          1'b1, '{ST_OK,   7'd2, 8'd4}},
    '{CMD_UNUSED, 32'sd0,           1'b1, '{ST_OK,   7'd3, 8'd4}},
    '{CMD_UNUSED, 32'sd5,           1'b1, '{ST_MISS, 7'd0, 8'd4}},
    '{CMD_REMOVE, 32'sh7FFF_FFFF,   1'b1, '{ST_OK,   7'd1, 8'd3}},
    '{CMD_LOOKUP, -32'sd1,          1'b1, '{ST_OK,   7'd1, 8'd3}},
    '{CMD_LOOKUP, 32'sd0,           1'b1, '{ST_OK,   7'd2, 8'd3}},
    '{CMD_REMOVE, 32'sh8000_0000,   1'b1, '{ST_OK,   7'd0, 8'd2}},
    '{CMD_REMOVE, 32'sd0,           1'b1, '{ST_OK,   7'd1, 8'd1}},
    '{CMD_REMOVE, 32'sd0,           1'b1, '{ST_MISS, 7'd0, 8'd1}},
    '{CMD_INSERT, 32'sd100,         1'b0, '0},
    '{CMD_INSERT, 32'sh5555_5555,   1'b0, '0},
    '{CMD_LOOKUP, 32'shAAAA_AAAA,   1'b0, '0},
    '{CMD_REMOVE, -32'sd1,          1'b0, '0}
  };

  // Apply one request to the predicted table and return the result it owes.
  function automatic set_result_t apply_request(input logic [1:0] cmd,
                                                input logic signed [31:0] value);
    set_result_t res;
    int          at;
    at = -1;
    foreach (set_contents[i]) begin
      if (at < 0 && set_contents[i] == value) at = i;
    end
    res.status   = ST_OK;
    res.position = '0;
    case (cmd)
      CMD_INSERT: begin
        // A held value wins over a full table.
        if (at >= 0) begin
          res.status = ST_MISS;
        end else if (set_contents.size() >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          res.position = 7'(set_contents.size());
          set_contents.push_back(value);
        end
      end
      CMD_REMOVE: begin
        // Later entries close up behind the removed one.
        if (at < 0) begin
          res.status = ST_MISS;
        end else begin
          res.position = 7'(at);
          set_contents.delete(at);
        end
      end
      default: begin
        if (at < 0) res.status = ST_MISS;
        else res.position = 7'(at);
      end
    endcase
    res.entry_count = 8'(set_contents.size());
    return res;
  endfunction

  // Mix small values (collisions), extremes and full-range values (every bit).
  function automatic logic signed [31:0] draw_value();
    case ($urandom_range(0, 5))
      0:       return $signed(32'($urandom_range(0, 12))) - 32'sd6;
      1:       return boundary_values[$urandom_range(0, 3)];
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic void remember_value(input logic signed [31:0] value);
    value_pool.push_back(value);
    if (value_pool.size() > POOL_LIMIT) void'(value_pool.pop_front());
  endfunction

  // Pick a value that is probably held; drop it from the pool when removing.
  function automatic logic signed [31:0] take_from_pool(input bit drop);
    int                 idx;
    logic signed [31:0] value;
    if (value_pool.size() == 0) return draw_value();
    idx   = $urandom_range(0, value_pool.size() - 1);
    value = value_pool[idx];
    if (drop) value_pool.delete(idx);
    return value;
  endfunction

  // Fill episodes are insert-heavy so the table reaches full and stays there a while;
  // drain episodes are remove-heavy so it empties again.
  function automatic request_row_t make_random_row(input bit filling);
    request_row_t row;
    int           roll;
    row.typed  = 1'b0;
    row.result = '0;
    roll       = $urandom_range(0, 99);
    if (filling) begin
      if (roll < 70) begin
        row.cmd   = CMD_INSERT;
        row.value = draw_value();
        remember_value(row.value);
      end else if (roll < 80) begin
        row.cmd   = CMD_INSERT;
        row.value = take_from_pool(1'b0);
      end else if (roll < 88) begin
        row.cmd   = CMD_LOOKUP;
        row.value = roll[0] ? take_from_pool(1'b0) : draw_value();
      end else if (roll < 95) begin
        row.cmd   = CMD_REMOVE;
        row.value = take_from_pool(1'b1);
      end else begin
        row.cmd   = CMD_UNUSED;
        row.value = roll[0] ? take_from_pool(1'b0) : draw_value();
      end
    end else begin
      if (roll < 60) begin
        row.cmd   = CMD_REMOVE;
        row.value = take_from_pool(1'b1);
      end else if (roll < 70) begin
        row.cmd   = CMD_REMOVE;
        row.value = draw_value();
      end else if (roll < 82) begin
        row.cmd   = CMD_INSERT;
        row.value = draw_value();
        remember_value(row.value);
      end else if (roll < 95) begin
        row.cmd   = CMD_LOOKUP;
        row.value = roll[0] ? take_from_pool(1'b0) : draw_value();
      end else begin
        row.cmd   = CMD_UNUSED;
        row.value = roll[0] ? take_from_pool(1'b0) : draw_value();
      end
    end
    return row;
  endfunction

  function automatic void note_error(input string what, input set_result_t want,
                                     input set_result_t got);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected status %0d position %0d count %0d,",
               $realtime, what, want.status, want.position, want.entry_count,
               " got status %0d position %0d count %0d",
               got.status, got.position, got.entry_count);
    end
  endfunction

  // Hold off for the drawn gap, present the item, then wait for its handshake.
  // Valid stays high across back-to-back items and is only lowered for a gap.
  task automatic send_request(input request_row_t row);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pending_requests.push_back(row);
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= row.cmd;
    in_ch.item_value <= row.value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Request side: reset, directed table, random episodes, then wait for the tail.
  initial begin
    error_count      = 0;
    idle_on          = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_LOOKUP;
    in_ch.item_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_request(directed_rows[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Redraw the idling mode now and then so quiet stretches alternate with busy ones.
      if (n % IDLE_BLOCK == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_request(make_random_row((n / EPISODE_LEN) % 2 == 0));
    end
    in_ch.valid <= 1'b0;

    // Drain every owed result, then give the block time to show any stray one.
    do @(posedge clk); while (expected_results.size() != 0 || pending_requests.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  // Result side: draw a stall per item, then hold ready until the item moves.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = idle_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Monitor both handshakes. Inputs are predicted before outputs are checked;
  // a result can never belong to an item accepted on the same edge.
  always @(posedge clk) begin
    request_row_t req;
    set_result_t  want;
    set_result_t  got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        req  = pending_requests.pop_front();
        want = apply_request(in_ch.cmd, in_ch.item_value);
        // Typed rows are checked against their written result; the predictor still advances.
        if (req.typed) want = req.result;
        expected_results.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.position, out_ch.entry_count};
        if (expected_results.size() == 0) begin
          note_error("result with nothing expected", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.position !== want.position ||
              got.entry_count !== want.entry_count) begin
            note_error("result mismatch", want, got);
          end
        end
      end
    end
  end

  // Stop a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("testbench NOT OK");
    $finish;
  end

endmodule
